@@ design/shwf_pkg.sv @@
// shared constants, register indexes and sequencer states for the history window feature block
package shwf_pkg;

  localparam int DEF_HISTORY_DEPTH = 24;
  localparam int DEF_LOG_INTERVAL  = 3600;
  localparam int DEF_SAMPLE_WIDTH  = 16;

  localparam int NUM_CHANNELS = 5;
  localparam int NUM_CFG      = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int TIME_W       = 32;
  localparam int NUM_FLAGS    = 4;

  // channel lanes in a history word
  localparam int CH_MOISTURE    = 0;
  localparam int CH_LIGHT       = 1;
  localparam int CH_TEMPERATURE = 2;
  localparam int CH_HUMIDITY    = 3;
  localparam int CH_AIRFLOW     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOISTURE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOISTURE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY_MIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY_MAX    = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  // handshake between the sequencer and the shared divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

@@ design/sensor_history_window_features.sv @@
// top level: sensor history ring, window averages, range offsets and flags
//
// One input word carries five signed Q8.8 readings and a seconds timestamp.
// The first word after reset, and any word at least LOG_INTERVAL seconds
// (mod 2^32) after the last logged one, is written into the history ring.
// Each input word gives exactly one result word: five window averages,
// four doubled midpoint offsets, range flags and the logged bit.
// Per word: the word is accepted, the filled entries are summed through the
// ram read port, then each channel sum goes through the shared serial
// divider (start, one step per quotient bit, done), which is skipped when
// the window is empty, and the result stays in the output register. With
// the defaults (24 entries, 16-bit samples) SUM_W is 21.
// in_stall is high from acceptance until the result word is taken, so one
// word is in flight at a time; while out_stall is high the result holds.
// Synchronous reset clears the ring pointer, the full flag, the last log
// time and the sequencer and loads the range registers with full-scale
// bounds; history contents are not cleared, only written entries are read.
// Configuration writes are taken in any cycle and must happen while idle.
module sensor_history_window_features #(
  parameter int HISTORY_DEPTH = shwf_pkg::DEF_HISTORY_DEPTH,
  parameter int LOG_INTERVAL  = shwf_pkg::DEF_LOG_INTERVAL,
  parameter int SAMPLE_WIDTH  = shwf_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                cfg_we,
  input  logic [shwf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]             cfg_data,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_moisture_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_light_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_temperature_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_humidity_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_airflow_sample,
  input  logic [shwf_pkg::TIME_W-1:0]         in_time_seconds,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_avg_moisture,
  output logic signed [SAMPLE_WIDTH-1:0]      out_avg_light,
  output logic signed [SAMPLE_WIDTH-1:0]      out_avg_temperature,
  output logic signed [SAMPLE_WIDTH-1:0]      out_avg_humidity,
  output logic signed [SAMPLE_WIDTH-1:0]      out_avg_airflow,
  output logic signed [SAMPLE_WIDTH+1:0]      out_moisture_offset2,
  output logic signed [SAMPLE_WIDTH+1:0]      out_light_offset2,
  output logic signed [SAMPLE_WIDTH+1:0]      out_temperature_offset2,
  output logic signed [SAMPLE_WIDTH+1:0]      out_humidity_offset2,
  output logic [shwf_pkg::NUM_FLAGS-1:0]      out_range_flags,
  output logic                                out_sample_logged
);

  localparam int NCH   = shwf_pkg::NUM_CHANNELS;
  localparam int NCFG  = shwf_pkg::NUM_CFG;
  localparam int NOFF  = shwf_pkg::NUM_FLAGS;
  localparam int TW    = shwf_pkg::TIME_W;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
  localparam int OFF_W = SAMPLE_WIDTH + 2;
  localparam int CH_W  = $clog2(NCH);
  localparam int WORD_W = NCH * SAMPLE_WIDTH;

  shwf_pkg::state_t state_r, state_nxt;

  logic signed [SW-1:0] cfg_r [NCFG];

  logic [AW-1:0]    write_slot_r;
  logic             window_full_r;
  logic [TW-1:0]    last_log_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] iss_r;
  logic             pend_r;
  logic [CH_W-1:0]  ch_r;
  logic             started_r;

  logic signed [SUM_W-1:0] acc_r [NCH];
  logic signed [SW-1:0]    avg_r [NCH];
  logic signed [OFF_W-1:0] off_r [NOFF];
  logic [NOFF-1:0]         flags_r;
  logic                    logged_r;

  logic signed [SW-1:0]    smp_in [NCH];
  logic signed [OFF_W-1:0] off_in [NOFF];
  logic [NOFF-1:0]         oor;
  logic [NOFF-1:0]         flags_in;
  logic [TW-1:0]           elapsed;
  logic                    do_log;
  logic                    slot_wrap;
  logic [AW-1:0]           slot_new;
  logic                    full_new;
  logic [CNT_W-1:0]        count_new;
  logic                    accept;
  logic                    issue;
  logic                    sum_done;
  logic [WORD_W-1:0]       wdata;
  logic [WORD_W-1:0]       rdata;

  shwf_pkg::div_req_t      div_req;
  shwf_pkg::div_rsp_t      div_rsp;
  logic signed [SUM_W-1:0] div_quo;

  // accept-time decisions
  always_comb begin
    smp_in[shwf_pkg::CH_MOISTURE]    = in_moisture_sample;
    smp_in[shwf_pkg::CH_LIGHT]       = in_light_sample;
    smp_in[shwf_pkg::CH_TEMPERATURE] = in_temperature_sample;
    smp_in[shwf_pkg::CH_HUMIDITY]    = in_humidity_sample;
    smp_in[shwf_pkg::CH_AIRFLOW]     = in_airflow_sample;

    for (int c = 0; c < NCH; c++) begin
      wdata[c*SW +: SW] = smp_in[c];
    end

    elapsed   = in_time_seconds - last_log_r;
    do_log    = ((write_slot_r == '0) && !window_full_r) || (elapsed >= TW'(LOG_INTERVAL));
    slot_wrap = write_slot_r == AW'(HISTORY_DEPTH - 1);
    slot_new  = write_slot_r;
    if (do_log) begin
      slot_new = slot_wrap ? '0 : write_slot_r + 1'b1;
    end
    full_new  = window_full_r | (do_log & slot_wrap);
    count_new = full_new ? CNT_W'(HISTORY_DEPTH) : CNT_W'(slot_new);

    // offsets and flags for the four ranged channels, register pair 2c and 2c+1
    for (int c = 0; c < NOFF; c++) begin
      off_in[c] = (OFF_W'(smp_in[c]) <<< 1) - OFF_W'(cfg_r[2*c]) - OFF_W'(cfg_r[2*c+1]);
      oor[c]    = (smp_in[c] < cfg_r[2*c]) || (smp_in[c] > cfg_r[2*c+1]);
    end
    flags_in = {oor[shwf_pkg::CH_LIGHT], oor[shwf_pkg::CH_MOISTURE],
                oor[shwf_pkg::CH_HUMIDITY], oor[shwf_pkg::CH_TEMPERATURE]};
  end

  assign accept   = in_valid && !in_stall;
  assign issue    = (state_r == shwf_pkg::ST_SUM) && (iss_r < count_r);
  assign sum_done = (state_r == shwf_pkg::ST_SUM) && !issue && !pend_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      shwf_pkg::ST_IDLE: begin
        if (accept) state_nxt = shwf_pkg::ST_SUM;
      end
      shwf_pkg::ST_SUM: begin
        if (sum_done) state_nxt = (count_r == '0) ? shwf_pkg::ST_OUT : shwf_pkg::ST_DIV;
      end
      shwf_pkg::ST_DIV: begin
        if (div_rsp.done && (ch_r == CH_W'(NCH - 1))) state_nxt = shwf_pkg::ST_OUT;
      end
      shwf_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = shwf_pkg::ST_IDLE;
      end
      default: state_nxt = shwf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    div_req.start = 1'b0;
    case (state_r)
      shwf_pkg::ST_IDLE: in_stall = !rst_n;
      shwf_pkg::ST_SUM:  ;
      shwf_pkg::ST_DIV:  div_req.start = !started_r;
      shwf_pkg::ST_OUT:  out_valid = 1'b1;
      default:           ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= shwf_pkg::ST_IDLE;
      write_slot_r  <= '0;
      window_full_r <= 1'b0;
      last_log_r    <= '0;
      count_r       <= '0;
      iss_r         <= '0;
      pend_r        <= 1'b0;
      ch_r          <= '0;
      started_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (accept) begin
        write_slot_r  <= slot_new;
        window_full_r <= full_new;
        count_r       <= count_new;
        iss_r         <= '0;
        ch_r          <= '0;
        started_r     <= 1'b0;
        if (do_log) last_log_r <= in_time_seconds;
      end
      if (issue) iss_r <= iss_r + 1'b1;
      if (div_req.start) started_r <= 1'b1;
      if (div_rsp.done) begin
        started_r <= 1'b0;
        ch_r      <= ch_r + 1'b1;
      end
    end
  end

  // range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCFG; i += 2) begin
        cfg_r[i]   <= {1'b1, {(SW-1){1'b0}}};
        cfg_r[i+1] <= {1'b0, {(SW-1){1'b1}}};
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < NCH; c++) begin
        acc_r[c] <= '0;
        avg_r[c] <= smp_in[c];  // empty window falls back to the current word
      end
      for (int c = 0; c < NOFF; c++) begin
        off_r[c] <= off_in[c];
      end
      flags_r  <= flags_in;
      logged_r <= do_log;
    end
    if (pend_r) begin
      for (int c = 0; c < NCH; c++) begin
        acc_r[c] <= acc_r[c] + SUM_W'($signed(rdata[c*SW +: SW]));
      end
    end
    if (div_rsp.done) begin
      avg_r[ch_r] <= div_quo[SW-1:0];
    end
  end

  shwf_ram #(
    .WIDTH(WORD_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (accept && do_log),
    .waddr(write_slot_r),
    .wdata(wdata),
    .raddr(iss_r[AW-1:0]),
    .rdata(rdata)
  );

  shwf_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .dividend(acc_r[ch_r]),
    .divisor (count_r),
    .rsp     (div_rsp),
    .quotient(div_quo)
  );

  assign out_avg_moisture        = avg_r[shwf_pkg::CH_MOISTURE];
  assign out_avg_light           = avg_r[shwf_pkg::CH_LIGHT];
  assign out_avg_temperature     = avg_r[shwf_pkg::CH_TEMPERATURE];
  assign out_avg_humidity        = avg_r[shwf_pkg::CH_HUMIDITY];
  assign out_avg_airflow         = avg_r[shwf_pkg::CH_AIRFLOW];
  assign out_moisture_offset2    = off_r[shwf_pkg::CH_MOISTURE];
  assign out_light_offset2       = off_r[shwf_pkg::CH_LIGHT];
  assign out_temperature_offset2 = off_r[shwf_pkg::CH_TEMPERATURE];
  assign out_humidity_offset2    = off_r[shwf_pkg::CH_HUMIDITY];
  assign out_range_flags         = flags_r;
  assign out_sample_logged       = logged_r;

endmodule

@@ design/shwf_ram.sv @@
// generic single write port, single read port ram with registered read
module shwf_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/shwf_div.sv @@
// iterative signed by unsigned restoring divider, one quotient bit per cycle, truncates toward zero
module shwf_div #(
  parameter int DIVIDEND_W = 21,
  parameter int DIVISOR_W  = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  shwf_pkg::div_req_t           req,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output shwf_pkg::div_rsp_t           rsp,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVIDEND_W-1:0] mag;

  always_comb begin
    mag   = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = trial >= {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIVIDEND_W);
      rem_nxt  = '0;
      quo_nxt  = mag;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[DIVIDEND_W-1];
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

@@ verif/shwf_feature_checker.sv @@
// checker for the history window feature block: predicts each result word and compares it
`timescale 1ns / 100ps

module shwf_feature_checker (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [shwf_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     cfg_data,
  input  logic                                      in_valid,
  input  logic                                      in_stall,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     in_moisture_sample,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     in_light_sample,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     in_temperature_sample,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     in_humidity_sample,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     in_airflow_sample,
  input  logic [shwf_pkg::TIME_W-1:0]               in_time_seconds,
  input  logic                                      out_valid,
  input  logic                                      out_stall,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     out_avg_moisture,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     out_avg_light,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     out_avg_temperature,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     out_avg_humidity,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH-1:0]     out_avg_airflow,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH+1:0]     out_moisture_offset2,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH+1:0]     out_light_offset2,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH+1:0]     out_temperature_offset2,
  input  logic [shwf_pkg::DEF_SAMPLE_WIDTH+1:0]     out_humidity_offset2,
  input  logic [shwf_pkg::NUM_FLAGS-1:0]            out_range_flags,
  input  logic                                      out_sample_logged,
  output int                                        failures,
  output int                                        pending,
  output int                                        checked_cnt,
  output int                                        logged_cnt,
  output int                                        wrap_cnt
);

  localparam int SW     = shwf_pkg::DEF_SAMPLE_WIDTH;
  localparam int NCH    = shwf_pkg::NUM_CHANNELS;
  localparam int DEPTH  = shwf_pkg::DEF_HISTORY_DEPTH;
  localparam int NFL    = shwf_pkg::NUM_FLAGS;
  localparam int NCFG   = shwf_pkg::NUM_CFG;
  localparam int TW     = shwf_pkg::TIME_W;
  localparam int LOG_IV = shwf_pkg::DEF_LOG_INTERVAL;

  // bit positions in range_flags
  localparam int FLAG_TEMPERATURE = 0;
  localparam int FLAG_HUMIDITY    = 1;
  localparam int FLAG_MOISTURE    = 2;
  localparam int FLAG_LIGHT       = 3;

  typedef struct packed {
    logic [NCH-1:0][SW-1:0]   avg;
    logic [NFL-1:0][SW+1:0]   off2;
    logic [NFL-1:0]           flags;
    logic                     logged;
  } features_t;

  // predictor state
  logic signed [SW-1:0] hist [NCH][DEPTH];
  logic signed [SW-1:0] bounds [NCFG];
  int                   next_slot;
  logic                 ring_full;
  logic [TW-1:0]        last_logged_at;

  features_t expected_features [$];

  string avg_name [NCH] = '{"avg_moisture", "avg_light", "avg_temperature",
                            "avg_humidity", "avg_airflow"};
  string off_name [NFL] = '{"moisture_offset2", "light_offset2",
                            "temperature_offset2", "humidity_offset2"};

  function automatic logic outside(input logic [SW-1:0] smp, input logic signed [SW-1:0] lo,
                                   input logic signed [SW-1:0] hi);
    return ($signed(smp) < lo) || ($signed(smp) > hi);
  endfunction

  function automatic features_t predict_features(input logic [NCH-1:0][SW-1:0] smp,
                                                 input logic [TW-1:0] now);
    features_t     f;
    logic [TW-1:0] elapsed;
    longint        acc, quot, diff2;
    int            c, j, filled;
    f = '0;
    elapsed = now - last_logged_at;
    // first word after reset always goes into the ring
    if ((next_slot == 0 && !ring_full) || elapsed >= LOG_IV) begin
      for (c = 0; c < NCH; c++) hist[c][next_slot] = smp[c];
      next_slot = (next_slot + 1) % DEPTH;
      if (next_slot == 0) begin
        ring_full = 1'b1;
        wrap_cnt++;
      end
      last_logged_at = now;
      f.logged = 1'b1;
      logged_cnt++;
    end
    filled = ring_full ? DEPTH : next_slot;
    for (c = 0; c < NCH; c++) begin
      if (filled > 0) begin
        acc = 0;
        for (j = 0; j < filled; j++) acc += hist[c][j];
        quot = acc / filled;
      end else begin
        quot = $signed(smp[c]);
      end
      f.avg[c] = quot[SW-1:0];
    end
    // min/max register pairs follow the channel order
    for (c = 0; c < NFL; c++) begin
      diff2 = 2 * longint'($signed(smp[c])) - bounds[2*c] - bounds[2*c+1];
      f.off2[c] = diff2[SW+1:0];
    end
    f.flags[FLAG_TEMPERATURE] = outside(smp[shwf_pkg::CH_TEMPERATURE],
                                        bounds[shwf_pkg::CFG_TEMPERATURE_MIN],
                                        bounds[shwf_pkg::CFG_TEMPERATURE_MAX]);
    f.flags[FLAG_HUMIDITY]    = outside(smp[shwf_pkg::CH_HUMIDITY],
                                        bounds[shwf_pkg::CFG_HUMIDITY_MIN],
                                        bounds[shwf_pkg::CFG_HUMIDITY_MAX]);
    f.flags[FLAG_MOISTURE]    = outside(smp[shwf_pkg::CH_MOISTURE],
                                        bounds[shwf_pkg::CFG_MOISTURE_MIN],
                                        bounds[shwf_pkg::CFG_MOISTURE_MAX]);
    f.flags[FLAG_LIGHT]       = outside(smp[shwf_pkg::CH_LIGHT],
                                        bounds[shwf_pkg::CFG_LIGHT_MIN],
                                        bounds[shwf_pkg::CFG_LIGHT_MAX]);
    return f;
  endfunction

  always @(posedge clk) begin : watch
    logic [NCH-1:0][SW-1:0] smp;
    features_t              act, exp_f;
    int                     c;
    if (!rst_n) begin
      expected_features.delete();
      next_slot      = 0;
      ring_full      = 1'b0;
      last_logged_at = '0;
      failures       = 0;
      checked_cnt    = 0;
      logged_cnt     = 0;
      wrap_cnt       = 0;
      for (c = 0; c < NCFG; c += 2) begin
        bounds[c]     = {1'b1, {(SW-1){1'b0}}};
        bounds[c + 1] = {1'b0, {(SW-1){1'b1}}};
      end
    end else begin
      if (cfg_we) bounds[cfg_index] = cfg_data;

      if (in_valid && !in_stall) begin
        smp[shwf_pkg::CH_MOISTURE]    = in_moisture_sample;
        smp[shwf_pkg::CH_LIGHT]       = in_light_sample;
        smp[shwf_pkg::CH_TEMPERATURE] = in_temperature_sample;
        smp[shwf_pkg::CH_HUMIDITY]    = in_humidity_sample;
        smp[shwf_pkg::CH_AIRFLOW]     = in_airflow_sample;
        expected_features.push_back(predict_features(smp, in_time_seconds));
      end

      if (out_valid && !out_stall) begin
        act.avg[shwf_pkg::CH_MOISTURE]     = out_avg_moisture;
        act.avg[shwf_pkg::CH_LIGHT]        = out_avg_light;
        act.avg[shwf_pkg::CH_TEMPERATURE]  = out_avg_temperature;
        act.avg[shwf_pkg::CH_HUMIDITY]     = out_avg_humidity;
        act.avg[shwf_pkg::CH_AIRFLOW]      = out_avg_airflow;
        act.off2[shwf_pkg::CH_MOISTURE]    = out_moisture_offset2;
        act.off2[shwf_pkg::CH_LIGHT]       = out_light_offset2;
        act.off2[shwf_pkg::CH_TEMPERATURE] = out_temperature_offset2;
        act.off2[shwf_pkg::CH_HUMIDITY]    = out_humidity_offset2;
        act.flags  = out_range_flags;
        act.logged = out_sample_logged;
        if (expected_features.size() == 0) begin
          $error("result word with no reading outstanding");
          failures++;
        end else begin
          exp_f = expected_features.pop_front();
          checked_cnt++;
          for (c = 0; c < NCH; c++)
            if (act.avg[c] !== exp_f.avg[c]) begin
              $error("%s expected %0d got %0d", avg_name[c], $signed(exp_f.avg[c]),
                     $signed(act.avg[c]));
              failures++;
            end
          for (c = 0; c < NFL; c++)
            if (act.off2[c] !== exp_f.off2[c]) begin
              $error("%s expected %0d got %0d", off_name[c], $signed(exp_f.off2[c]),
                     $signed(act.off2[c]));
              failures++;
            end
          if (act.flags !== exp_f.flags) begin
            $error("range_flags expected %b got %b", exp_f.flags, act.flags);
            failures++;
          end
          if (act.logged !== exp_f.logged) begin
            $error("sample_logged expected %0d got %0d", exp_f.logged, act.logged);
            failures++;
          end
        end
      end
    end
    pending = expected_features.size();
  end

endmodule

@@ verif/sensor_history_window_features_test.sv @@
// testbench top: drives readings and range settings into the history window feature block
`timescale 1ns / 100ps

module sensor_history_window_features_test;

  localparam int SW          = shwf_pkg::DEF_SAMPLE_WIDTH;
  localparam int TW          = shwf_pkg::TIME_W;
  localparam int IW          = shwf_pkg::CFG_IDX_W;
  localparam int NFL         = shwf_pkg::NUM_FLAGS;
  localparam int LOG_IV      = shwf_pkg::DEF_LOG_INTERVAL;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 142;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef enum int {
    RANGE_ORDERED,
    RANGE_INVERTED,
    RANGE_FULL,
    RANGE_NARROW,
    RANGE_SWAPPED_FULL,
    RANGE_ANY,
    RANGE_QUARTER
  } range_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [IW-1:0]        cfg_index = '0;
  logic [SW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SW-1:0]        in_moisture_sample = '0;
  logic [SW-1:0]        in_light_sample = '0;
  logic [SW-1:0]        in_temperature_sample = '0;
  logic [SW-1:0]        in_humidity_sample = '0;
  logic [SW-1:0]        in_airflow_sample = '0;
  logic [TW-1:0]        in_time_seconds = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SW-1:0]        out_avg_moisture, out_avg_light, out_avg_temperature;
  logic [SW-1:0]        out_avg_humidity, out_avg_airflow;
  logic [SW+1:0]        out_moisture_offset2, out_light_offset2;
  logic [SW+1:0]        out_temperature_offset2, out_humidity_offset2;
  logic [NFL-1:0]       out_range_flags;
  logic                 out_sample_logged;

  int failures, pending, checked_cnt, logged_cnt, wrap_cnt;
  int cycles = 0;
  int gap_pct = 20;
  int stall_pct = 77;
  logic [TW-1:0] now_s = '0;

  sensor_history_window_features DUT (.*);
  shwf_feature_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sensor_history_window_features regression: fail");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= rst_n && ($urandom_range(99) < stall_pct);

  function automatic logic [SW-1:0] rand_sample();
    logic [SW-1:0] r;
    r = SW'($urandom);
    case ($urandom_range(7))
      0: r = S_MIN;
      1: r = S_MAX;
      2, 3: r = SW'(int'($urandom_range(2047)) - 1024);
      default: ;
    endcase
    return r;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_reading(input logic [SW-1:0] m, l, t, h, a,
                              input logic [TW-1:0] ts);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_moisture_sample    <= m;
    in_light_sample       <= l;
    in_temperature_sample <= t;
    in_humidity_sample    <= h;
    in_airflow_sample     <= a;
    in_time_seconds       <= ts;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [SW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // block must be idle; writes all eight bounds
  task automatic program_ranges(input range_kind_t kind);
    logic [SW-1:0] lo [4];
    logic [SW-1:0] hi [4];
    logic [SW-1:0] a, b;
    int c;
    for (c = 0; c < 4; c++) begin
      a = rand_sample();
      b = rand_sample();
      case (kind)
        RANGE_ORDERED: begin
          lo[c] = ($signed(a) <= $signed(b)) ? a : b;
          hi[c] = ($signed(a) <= $signed(b)) ? b : a;
        end
        RANGE_INVERTED: begin
          lo[c] = ($signed(a) >= $signed(b)) ? a : b;
          hi[c] = ($signed(a) >= $signed(b)) ? b : a;
        end
        RANGE_FULL: begin
          lo[c] = S_MIN;
          hi[c] = S_MAX;
        end
        RANGE_NARROW: begin
          lo[c] = SW'(-int'($urandom_range(600)));
          hi[c] = SW'($urandom_range(600));
        end
        RANGE_SWAPPED_FULL: begin
          lo[c] = S_MAX;
          hi[c] = S_MIN;
        end
        RANGE_QUARTER: begin
          lo[c] = SW'(-256);
          hi[c] = SW'(256);
        end
        default: begin
          lo[c] = a;
          hi[c] = b;
        end
      endcase
    end
    write_reg(shwf_pkg::CFG_MOISTURE_MIN, lo[0]);
    write_reg(shwf_pkg::CFG_MOISTURE_MAX, hi[0]);
    write_reg(shwf_pkg::CFG_LIGHT_MIN, lo[1]);
    write_reg(shwf_pkg::CFG_LIGHT_MAX, hi[1]);
    write_reg(shwf_pkg::CFG_TEMPERATURE_MIN, lo[2]);
    write_reg(shwf_pkg::CFG_TEMPERATURE_MAX, hi[2]);
    write_reg(shwf_pkg::CFG_HUMIDITY_MIN, lo[3]);
    write_reg(shwf_pkg::CFG_HUMIDITY_MAX, hi[3]);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int p, i, k, pick;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset bounds; first word logged although little time has passed
    send_reading('0, '0, '0, '0, '0, 32'd5);
    send_reading(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 32'd6);
    // one second short of the interval, then exactly the interval
    send_reading(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 32'd3604);
    send_reading(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 32'd3605);
    // sum of -1 over three entries truncates to zero
    send_reading(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 32'd7205);
    send_reading('1, '1, '1, '1, '1, 32'd10805);
    // timestamp wraps past 2^32
    send_reading(16'h0100, 16'hff00, S_MAX, S_MIN, 16'h1234, 32'hffff_f000);
    send_reading(16'h5a5a, 16'ha5a5, 16'h0001, 16'hfffe, S_MIN, 32'h0000_0300);
    send_reading(16'h00ff, 16'h7f00, 16'h8001, 16'h0000, S_MAX, 32'h0000_0400);

    // min above max: every value is flagged
    drain();
    program_ranges(RANGE_SWAPPED_FULL);
    now_s = 32'h0000_1400;
    send_reading(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, now_s);
    send_reading(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, now_s + 1);
    send_reading('0, '0, '0, '0, '0, now_s + LOG_IV);

    // bounds are inclusive: one past each edge is flagged
    drain();
    program_ranges(RANGE_QUARTER);
    now_s = now_s + 2 * LOG_IV;
    send_reading(16'hfeff, 16'h0101, 16'h0100, 16'hff00, '0, now_s);
    send_reading(16'hff00, 16'h0100, 16'hfeff, 16'h0101, S_MAX, now_s + LOG_IV);
    send_reading('0, '0, '0, '0, S_MIN, now_s + LOG_IV + 1);
    now_s = now_s + LOG_IV + 1;

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      program_ranges(range_kind_t'(p));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        k = p * PHASE_ITEMS + i;
        if (k < NUM_PHASES * PHASE_ITEMS / 3) begin
          gap_pct = 20;
          stall_pct = 77;
        end else if (k < 2 * NUM_PHASES * PHASE_ITEMS / 3) begin
          gap_pct = 77;
          stall_pct = 20;
        end else begin
          gap_pct = 0;
          stall_pct = 0;
        end
        // mostly steady time steps, some exact intervals, a few jumps and wraps
        pick = $urandom_range(99);
        if (pick < 4)
          now_s = $urandom;
        else if (pick < 10)
          now_s = now_s + LOG_IV;
        else if (pick < 13)
          now_s = 32'hffff_ffff - $urandom_range(2 * LOG_IV);
        else if (pick < 58)
          now_s = now_s + $urandom_range(LOG_IV - 1);
        else
          now_s = now_s + LOG_IV + $urandom_range(2 * LOG_IV);
        send_reading(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                     rand_sample(), now_s);
      end
    end

    drain();
    repeat (200) @(negedge clk);
    $display("checked %0d result words; %0d readings went into history, ring wrapped %0d times",
             checked_cnt, logged_cnt, wrap_cnt);
    $display("bounds covered: reset, full scale, swapped, inclusive edges, narrow, random");
    if (failures == 0 && pending == 0)
      $display("sensor_history_window_features regression: pass");
    else
      $display("sensor_history_window_features regression: fail");
    $finish;
  end

endmodule
